>>> rtl/jpa_pkg.sv
`default_nettype none
package jpa_pkg;

   localparam int SUM_W = 68;
   localparam int TC_W = 100;
   localparam int A_W = 120;
   localparam int NORM_BITS = 59;
   localparam int GROUPS = 15;
   localparam int CORDIC_STEPS = 30;
   localparam int ROOT_STEPS = 61;
   localparam int ROOT_W = 122;

   localparam logic [16:0] GAMMA_ONE = 17'd65536;

   localparam logic signed [39:0] PI_Q30 = 40'sd3373259426;
   localparam logic signed [39:0] THREE_PI_8_Q32 = 40'sd5059889139;
   localparam logic signed [39:0] HALF_PI_Q32 = 40'sd6746518853;
   localparam logic signed [31:0] THETA_LIMIT = 32'sd632486143;

   typedef enum logic [7:0] {
      CSR_GAMMA = 8'd0,
      CSR_SCALE = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic                zero;
      logic                a1_neg;
      logic                a2_neg;
      logic signed [7:0]   k;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [58:0]         u;
      logic signed [63:0]  x;
      logic signed [63:0]  y;
      logic signed [33:0]  z;
      logic [121:0]        op;
      logic [121:0]        res;
   } step_type;

   function automatic logic signed [33:0] atan_entry(input int idx);
      logic signed [33:0] one_v;
      logic signed [33:0] r;
      one_v = 34'sd1;
      case (idx)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021687;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         default: r = (idx <= 30) ? (one_v <<< (30 - idx)) : 34'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/jpa_terms.sv
`default_nettype none
module jpa_terms (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [31:0]  dx_ii,
   input  wire logic signed [31:0]  dx_jj,
   input  wire logic signed [31:0]  dx_ij,
   input  wire logic signed [31:0]  dy_ii,
   input  wire logic signed [31:0]  dy_jj,
   input  wire logic signed [31:0]  dy_ij,
   input  wire logic signed [31:0]  dz_ii,
   input  wire logic signed [31:0]  dz_jj,
   input  wire logic signed [31:0]  dz_ij,
   input  wire logic signed [31:0]  h_ii,
   input  wire logic signed [31:0]  h_jj,
   input  wire logic signed [31:0]  h_ij,
   input  wire logic [16:0]         gamma_weight,
   input  wire logic signed [31:0]  energy_scale,
   output logic                     out_valid,
   output logic signed [119:0]      a1,
   output logic signed [119:0]      a2
);
   import jpa_pkg::*;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [32:0]  d_in [4];
   logic signed [32:0]  d_ff [4];
   logic signed [31:0]  o_in [4];
   logic signed [31:0]  o_ff [4];
   logic signed [63:0]  oo_in [4];
   logic signed [63:0]  oo_ff [4];
   logic signed [65:0]  dd_in [4];
   logic signed [65:0]  dd_ff [4];
   logic signed [64:0]  od_in [4];
   logic signed [64:0]  od_ff [4];
   logic signed [SUM_W-1:0] s1_in, s2_in, t1_in, t2_in;
   logic signed [SUM_W-1:0] s1_ff, s2_ff, t1_ff, t2_ff;
   logic signed [SUM_W-1:0] s1b_ff, s2b_ff, s1c_ff, s2c_ff;
   logic signed [66:0]  p1l_in, p2l_in, p1l_ff, p2l_ff;
   logic signed [65:0]  p1h_in, p2h_in, p1h_ff, p2h_ff;
   logic signed [TC_W-1:0] tc1_in, tc2_in, tc1_ff, tc2_ff;
   logic [16:0]         geff;
   logic [16:0]         gcomp;
   logic signed [17:0]  g_s, gc_s;
   logic signed [85:0]  sp1_in, sp2_in, sp1_ff, sp2_ff;
   logic signed [68:0]  q1l_in, q2l_in, q1l_ff, q2l_ff;
   logic signed [67:0]  q1h_in, q2h_in, q1h_ff, q2h_ff;
   logic signed [A_W-1:0] a1_in, a2_in, a1_ff, a2_ff;

   always_comb begin
      d_in[0] = {dx_ii[31], dx_ii} - {dx_jj[31], dx_jj};
      d_in[1] = {dy_ii[31], dy_ii} - {dy_jj[31], dy_jj};
      d_in[2] = {dz_ii[31], dz_ii} - {dz_jj[31], dz_jj};
      d_in[3] = {h_ii[31], h_ii} - {h_jj[31], h_jj};
      o_in[0] = dx_ij;
      o_in[1] = dy_ij;
      o_in[2] = dz_ij;
      o_in[3] = h_ij;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         oo_in[i] = o_ff[i] * o_ff[i];
         dd_in[i] = d_ff[i] * d_ff[i];
         od_in[i] = o_ff[i] * d_ff[i];
      end
   end

   always_comb begin
      s1_in = '0;
      s2_in = '0;
      for (int i = 0; i < 3; i++) begin
         s1_in = s1_in + (SUM_W'(oo_ff[i]) <<< 2) - SUM_W'(dd_ff[i]);
         s2_in = s2_in - (SUM_W'(od_ff[i]) <<< 2);
      end
      t1_in = (SUM_W'(oo_ff[3]) <<< 2) - SUM_W'(dd_ff[3]);
      t2_in = -(SUM_W'(od_ff[3]) <<< 2);
   end

   always_comb begin
      p1l_in = $signed({1'b0, t1_ff[33:0]}) * energy_scale;
      p2l_in = $signed({1'b0, t2_ff[33:0]}) * energy_scale;
      p1h_in = $signed(t1_ff[67:34]) * energy_scale;
      p2h_in = $signed(t2_ff[67:34]) * energy_scale;
      tc1_in = (TC_W'(p1h_ff) <<< 34) + TC_W'(p1l_ff);
      tc2_in = (TC_W'(p2h_ff) <<< 34) + TC_W'(p2l_ff);
   end

   always_comb begin
      geff = (gamma_weight > GAMMA_ONE) ? GAMMA_ONE : gamma_weight;
      gcomp = GAMMA_ONE - geff;
      g_s = $signed({1'b0, geff});
      gc_s = $signed({1'b0, gcomp});
      sp1_in = s1c_ff * gc_s;
      sp2_in = s2c_ff * gc_s;
      q1l_in = $signed({1'b0, tc1_ff[49:0]}) * g_s;
      q2l_in = $signed({1'b0, tc2_ff[49:0]}) * g_s;
      q1h_in = $signed(tc1_ff[99:50]) * g_s;
      q2h_in = $signed(tc2_ff[99:50]) * g_s;
      a1_in = (A_W'(sp1_ff) <<< 16) + (A_W'(q1h_ff) <<< 50) + A_W'(q1l_ff);
      a2_in = (A_W'(sp2_ff) <<< 16) + (A_W'(q2h_ff) <<< 50) + A_W'(q2l_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            d_ff[i] <= d_in[i];
            o_ff[i] <= o_in[i];
            oo_ff[i] <= oo_in[i];
            dd_ff[i] <= dd_in[i];
            od_ff[i] <= od_in[i];
         end
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         s1b_ff <= s1_ff;
         s2b_ff <= s2_ff;
         p1l_ff <= p1l_in;
         p2l_ff <= p2l_in;
         p1h_ff <= p1h_in;
         p2h_ff <= p2h_in;
         s1c_ff <= s1b_ff;
         s2c_ff <= s2b_ff;
         tc1_ff <= tc1_in;
         tc2_ff <= tc2_in;
         sp1_ff <= sp1_in;
         sp2_ff <= sp2_in;
         q1l_ff <= q1l_in;
         q2l_ff <= q2l_in;
         q1h_ff <= q1h_in;
         q2h_ff <= q2h_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
      end
   end

   assign out_valid = v7_ff;
   assign a1 = a1_ff;
   assign a2 = a2_ff;

endmodule
`default_nettype wire

>>> rtl/jpa_norm.sv
`default_nettype none
module jpa_norm (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [119:0] a1,
   input  wire logic signed [119:0] a2,
   output logic                     out_valid,
   output jpa_pkg::side_type        side,
   output logic [58:0]              u,
   output logic [58:0]              v
);
   import jpa_pkg::*;

   logic                v1_ff, v2_ff, v3_ff;
   logic [A_W-1:0]      ua_in, ub_in, orv;
   logic [A_W-1:0]      ua_ff, ub_ff, ua2_ff, ub2_ff;
   side_type            side_in, side_ff, side_hold_ff, side_out_in, side_out_ff;
   logic [GROUPS-1:0]   nz_in, nz_ff;
   logic [2:0]          pos_in [GROUPS];
   logic [2:0]          pos_ff [GROUPS];
   logic [6:0]          bl_in, bl_ff;
   logic [A_W-1:0]      shu, shv;
   logic [6:0]          sh_amt;
   logic [58:0]         u_in, v_in, u_ff, v_ff;

   always_comb begin
      ua_in = a1[A_W-1] ? A_W'(-a1) : A_W'(a1);
      ub_in = a2[A_W-1] ? A_W'(-a2) : A_W'(a2);
      orv = ua_in | ub_in;
      side_in.zero = (a1 == '0) && (a2 == '0);
      side_in.a1_neg = a1[A_W-1];
      side_in.a2_neg = a2[A_W-1];
      side_in.k = '0;
      for (int g = 0; g < GROUPS; g++) begin
         nz_in[g] = |orv[8*g +: 8];
         pos_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (orv[8*g + b]) begin
               pos_in[g] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      bl_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (nz_ff[g]) begin
            bl_in = 7'(8*g) + 7'(pos_ff[g]) + 7'd1;
         end
      end
   end

   always_comb begin
      side_out_in = side_hold_ff;
      side_out_in.k = $signed({1'b0, bl_ff}) - 8'sd59;
      if (bl_ff > 7'(NORM_BITS)) begin
         sh_amt = bl_ff - 7'(NORM_BITS);
         shu = ua2_ff >> sh_amt;
         shv = ub2_ff >> sh_amt;
      end else begin
         sh_amt = 7'(NORM_BITS) - bl_ff;
         shu = ua2_ff << sh_amt;
         shv = ub2_ff << sh_amt;
      end
      u_in = shu[58:0];
      v_in = shv[58:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff <= ua_in;
         ub_ff <= ub_in;
         side_ff <= side_in;
         nz_ff <= nz_in;
         for (int g = 0; g < GROUPS; g++) begin
            pos_ff[g] <= pos_in[g];
         end
         ua2_ff <= ua_ff;
         ub2_ff <= ub_ff;
         bl_ff <= bl_in;
         side_hold_ff <= side_ff;
         u_ff <= u_in;
         v_ff <= v_in;
         side_out_ff <= side_out_in;
      end
   end

   assign out_valid = v3_ff;
   assign side = side_out_ff;
   assign u = u_ff;
   assign v = v_ff;

endmodule
`default_nettype wire

>>> rtl/jpa_step.sv
`default_nettype none
module jpa_step #(
   parameter int STEP_IDX = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  jpa_pkg::step_type in_step,
   output logic              out_valid,
   output jpa_pkg::step_type out_step
);
   import jpa_pkg::*;

   localparam int ROOT_BIT = ROOT_STEPS - 1 - STEP_IDX;
   localparam logic [ROOT_W-1:0] ONE_BIT = ROOT_W'(1) << (2 * ROOT_BIT);
   localparam logic signed [33:0] ANGLE = atan_entry(STEP_IDX);

   logic [ROOT_W-1:0]   trial;
   logic signed [63:0]  dx, dy;
   step_type            step_in, step_ff;
   logic                valid_ff;

   always_comb begin
      step_in = in_step;
      trial = in_step.res + ONE_BIT;
      if (in_step.op >= trial) begin
         step_in.op = in_step.op - trial;
         step_in.res = (in_step.res >> 1) + ONE_BIT;
      end else begin
         step_in.res = in_step.res >> 1;
      end
      dx = in_step.y >>> STEP_IDX;
      dy = in_step.x >>> STEP_IDX;
      if (STEP_IDX < CORDIC_STEPS) begin
         if (in_step.y > 64'sd0) begin
            step_in.x = in_step.x + dx;
            step_in.y = in_step.y - dy;
            step_in.z = in_step.z + ANGLE;
         end else begin
            step_in.x = in_step.x - dx;
            step_in.y = in_step.y + dy;
            step_in.z = in_step.z - ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_step = step_ff;

endmodule
`default_nettype wire

>>> rtl/jacobi_pair_angle.sv
// One request is taken per cycle whenever rsp_ready is high or no result is waiting.
// The depth is set by the 61 stages of the bit-per-stage square root, which also carry the
// 30 CORDIC vectoring steps of the angle.
// A result that is not taken holds the whole pipeline; nothing is lost or repeated.
// Reset clears every valid flag and returns gamma_weight to 0 and energy_scale to 1.0.
`default_nettype none
module jacobi_pair_angle #(
   parameter int DATA_FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [31:0]  req_dx_ii,
   input  wire logic signed [31:0]  req_dx_jj,
   input  wire logic signed [31:0]  req_dx_ij,
   input  wire logic signed [31:0]  req_dy_ii,
   input  wire logic signed [31:0]  req_dy_jj,
   input  wire logic signed [31:0]  req_dy_ij,
   input  wire logic signed [31:0]  req_dz_ii,
   input  wire logic signed [31:0]  req_dz_jj,
   input  wire logic signed [31:0]  req_dz_ij,
   input  wire logic signed [31:0]  req_h_ii,
   input  wire logic signed [31:0]  req_h_jj,
   input  wire logic signed [31:0]  req_h_ij,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_theta,
   output logic signed [63:0]       rsp_delta,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [7:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);
   import jpa_pkg::*;

   logic                en;
   logic [16:0]         gamma_ff;
   logic signed [31:0]  scale_ff;
   logic                terms_valid;
   logic signed [A_W-1:0] a1, a2;
   logic                norm_valid;
   side_type            norm_side;
   logic [58:0]         norm_u, norm_v;

   logic                q1_valid_ff, q2_valid_ff;
   side_type            q1_side_ff;
   logic [58:0]         q1_u_ff, q1_v_ff;
   logic [63:0]         pu_ll_in, pv_ll_in, pu_ll_ff, pv_ll_ff;
   logic [58:0]         pu_hl_in, pv_hl_in, pu_hl_ff, pv_hl_ff;
   logic [53:0]         pu_hh_in, pv_hh_in, pu_hh_ff, pv_hh_ff;
   step_type            q2_in, q2_ff;

   logic                chain_valid [ROOT_STEPS+1];
   step_type            chain_step [ROOT_STEPS+1];

   step_type            last;
   logic signed [39:0]  phi, th;
   logic [63:0]         rn, m, mag;
   logic signed [8:0]   ex;
   logic [8:0]          neg_ex;
   logic [127:0]        wide;
   logic signed [31:0]  theta_in, theta_ff;
   logic signed [63:0]  delta_in, delta_ff;
   logic                out_valid_ff;

   assign en = !out_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= '0;
         scale_ff <= 32'sd65536;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAMMA: gamma_ff <= csr_wdata[16:0];
            CSR_SCALE: scale_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   jpa_terms u_terms (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .dx_ii        (req_dx_ii),
      .dx_jj        (req_dx_jj),
      .dx_ij        (req_dx_ij),
      .dy_ii        (req_dy_ii),
      .dy_jj        (req_dy_jj),
      .dy_ij        (req_dy_ij),
      .dz_ii        (req_dz_ii),
      .dz_jj        (req_dz_jj),
      .dz_ij        (req_dz_ij),
      .h_ii         (req_h_ii),
      .h_jj         (req_h_jj),
      .h_ij         (req_h_ij),
      .gamma_weight (gamma_ff),
      .energy_scale (scale_ff),
      .out_valid    (terms_valid),
      .a1           (a1),
      .a2           (a2)
   );

   jpa_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (terms_valid),
      .a1        (a1),
      .a2        (a2),
      .out_valid (norm_valid),
      .side      (norm_side),
      .u         (norm_u),
      .v         (norm_v)
   );

   always_comb begin
      pu_ll_in = 64'(norm_u[31:0]) * 64'(norm_u[31:0]);
      pv_ll_in = 64'(norm_v[31:0]) * 64'(norm_v[31:0]);
      pu_hl_in = 59'(norm_u[58:32]) * 59'(norm_u[31:0]);
      pv_hl_in = 59'(norm_v[58:32]) * 59'(norm_v[31:0]);
      pu_hh_in = 54'(norm_u[58:32]) * 54'(norm_u[58:32]);
      pv_hh_in = 54'(norm_v[58:32]) * 54'(norm_v[58:32]);
   end

   always_comb begin
      q2_in.side = q1_side_ff;
      q2_in.u = q1_u_ff;
      q2_in.x = $signed(64'(q1_u_ff));
      q2_in.y = $signed(64'(q1_v_ff));
      q2_in.z = '0;
      q2_in.op = (ROOT_W'(pu_hh_ff) << 64) + (ROOT_W'(pu_hl_ff) << 33) + ROOT_W'(pu_ll_ff)
               + (ROOT_W'(pv_hh_ff) << 64) + (ROOT_W'(pv_hl_ff) << 33) + ROOT_W'(pv_ll_ff);
      q2_in.res = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         q1_valid_ff <= norm_valid;
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_side_ff <= norm_side;
         q1_u_ff <= norm_u;
         q1_v_ff <= norm_v;
         pu_ll_ff <= pu_ll_in;
         pv_ll_ff <= pv_ll_in;
         pu_hl_ff <= pu_hl_in;
         pv_hl_ff <= pv_hl_in;
         pu_hh_ff <= pu_hh_in;
         pv_hh_ff <= pv_hh_in;
         q2_ff <= q2_in;
      end
   end

   assign chain_valid[0] = q2_valid_ff;
   assign chain_step[0] = q2_ff;

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      jpa_step #(
         .STEP_IDX (s)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[s]),
         .in_step   (chain_step[s]),
         .out_valid (chain_valid[s+1]),
         .out_step  (chain_step[s+1])
      );
   end

   always_comb begin
      last = chain_step[ROOT_STEPS];
      phi = last.side.a1_neg ? PI_Q30 - 40'(last.z) : 40'(last.z);
      if (last.side.a2_neg) begin
         phi = -phi;
      end
      th = phi - PI_Q30;
      if (th > THREE_PI_8_Q32) begin
         th = th - HALF_PI_Q32;
      end
      if (th < -THREE_PI_8_Q32) begin
         th = th + HALF_PI_Q32;
      end
      th = (th + 40'sd4) >>> 3;

      rn = last.res[63:0];
      m = last.side.a1_neg ? rn - 64'(last.u) : rn + 64'(last.u);
      ex = $signed({last.side.k[7], last.side.k}) - 9'(2 * DATA_FRAC_BITS + 1);
      neg_ex = 9'(-ex);
      wide = 128'(m) << ex[7:0];
      if (!ex[8]) begin
         mag = (wide > (128'(1) << 63)) ? (64'(1) << 63) : wide[63:0];
      end else begin
         mag = m >> neg_ex;
      end

      if (last.side.zero) begin
         theta_in = '0;
         delta_in = '0;
      end else begin
         theta_in = th[31:0];
         delta_in = $signed(64'd0 - mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= chain_valid[ROOT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         theta_ff <= theta_in;
         delta_ff <= delta_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_theta = theta_ff;
   assign rsp_delta = delta_ff;

   a_delta_not_positive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delta[63] || rsp_delta == 64'sd0))
      else $error("predicted change is positive");

   a_theta_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_theta <= THETA_LIMIT && rsp_theta >= -THETA_LIMIT))
      else $error("angle outside the folded range");

   a_stall_only_when_held : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("pipeline stalled without a waiting result");

endmodule
`default_nettype wire
